[rtl/assert_macros.svh]
// Assertion helpers used by the checker file atan2c_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication checked a fixed number of cycles later.
`define CHK_LATER(label, clk_s, rst_s, ante, dly, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> ##dly (cons)) \
    else $error("delayed check failed");

`endif

[rtl/atan2c_pkg.sv]
`default_nettype none

package atan2c_pkg;

  // Input vector component width and output fraction bits
  localparam int IN_W = 16;
  localparam int AFB  = 13;

  // Ratio is Q1.15: 16 quotient bits, 17 bits once signed
  localparam int Q_W   = 16;
  localparam int R_W   = Q_W + 1;
  localparam int MAG_W = IN_W + 1;
  localparam int REM_W = MAG_W + 1;

  // Product widths of the polynomial datapath (ratio magnitude <= 2^15)
  localparam int R2_W = 31;
  localparam int A_W  = 29;
  localparam int L_W  = 31;
  localparam int C_W  = 60;

  // Q15 coefficients
  localparam logic signed [14:0] COEF_CUBE = 15'sd6432;
  localparam logic signed [16:0] COEF_LIN  = 17'sd32168;

  // Final shift from Q60 down to the angle fraction bits
  localparam int SH    = 60 - AFB;
  localparam int ANG_W = 64 - SH;
  localparam int OUT_W = 16;

  // Offsets in Q60 with the half-up rounding term folded in
  localparam logic signed [63:0] OFF_Q_RND  =
    64'sh0C90FDAA22168C23 + (64'sd1 <<< (SH - 1));
  localparam logic signed [63:0] OFF_3Q_RND =
    64'sh25B2F8FE6643A46A + (64'sd1 <<< (SH - 1));

  // Pipeline depth: one cell per quotient bit, then the polynomial stages
  localparam int POLY_LAT = 4;
  localparam int LAT      = Q_W + POLY_LAT;

  typedef struct packed {
    logic zero;
    logic neg_ang;
    logic hi_off;
    logic neg_q;
  } side_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

`default_nettype wire

[rtl/atan2c_div_cell.sv]
`default_nettype none

module atan2c_div_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  atan2c_pkg::div_t  d_in,
  output atan2c_pkg::div_t  d_out
);
  import atan2c_pkg::*;

  logic             ge;
  logic [MAG_W-1:0] diff;
  div_t             st_nxt;
  div_t             st_r;

  // Resolve one quotient bit: compare, subtract, double the remainder
  always_comb begin
    ge   = d_in.rem >= {1'b0, d_in.den};
    diff = ge ? MAG_W'(d_in.rem - {1'b0, d_in.den}) : d_in.rem[MAG_W-1:0];
    st_nxt     = d_in;
    st_nxt.rem = {diff, 1'b0};
    st_nxt.quo = {d_in.quo[Q_W-2:0], ge};
  end

  // Advance to the next cell every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign d_out = st_r;

endmodule

`default_nettype wire

[rtl/atan2c_poly.sv]
`default_nettype none

module atan2c_poly (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  atan2c_pkg::div_t                  d_in,
  output logic                              out_strobe,
  output logic signed [atan2c_pkg::OUT_W-1:0] out_angle
);
  import atan2c_pkg::*;

  localparam logic signed [ANG_W:0] SAT_HI = (ANG_W + 1)'(32767);
  localparam logic signed [ANG_W:0] SAT_LO = -(ANG_W + 1)'(32768);

  // Stage 1: signed ratio, its square and the two scaled terms
  logic signed [R_W-1:0]     r_s;
  logic signed [2*R_W-1:0]   r2_full;
  logic signed [R_W+14:0]    a_full;
  logic signed [2*R_W-1:0]   l_full;
  logic                      v1_r;
  side_t                     side1_r;
  logic [R2_W-1:0]           r2_r;
  logic signed [A_W-1:0]     a_r;
  logic signed [L_W-1:0]     l1_r;

  // Stage 2: cubic term
  logic signed [A_W+R2_W:0]  c_full;
  logic                      v2_r;
  side_t                     side2_r;
  logic signed [C_W-1:0]     c_r;
  logic signed [L_W-1:0]     l2_r;

  // Stage 3: Q60 sum with rounding
  logic signed [63:0]        cx;
  logic signed [63:0]        lx;
  logic signed [63:0]        off;
  logic signed [63:0]        sum_nxt;
  logic                      v3_r;
  side_t                     side3_r;
  logic signed [63:0]        sum_r;

  // Stage 4: shift, sign and clamp
  logic signed [ANG_W-1:0]   angm;
  logic signed [ANG_W:0]     angx;
  logic signed [ANG_W:0]     angn;
  logic signed [OUT_W-1:0]   ang_nxt;

  always_comb begin
    r_s = d_in.side.neg_q ? -$signed({1'b0, d_in.quo}) : $signed({1'b0, d_in.quo});
    r2_full = r_s * r_s;
    a_full  = r_s * COEF_CUBE;
    l_full  = r_s * COEF_LIN;
  end

  always_comb begin
    c_full = a_r * $signed({1'b0, r2_r});
  end

  always_comb begin
    cx      = 64'(c_r);
    lx      = 64'(l2_r) <<< 30;
    off     = side2_r.hi_off ? OFF_3Q_RND : OFF_Q_RND;
    sum_nxt = cx - lx + off;
  end

  // Floor shift, negate for lower half plane, saturate; a zero vector gives zero
  always_comb begin
    angm = $signed(sum_r[63:SH]);
    angx = {angm[ANG_W-1], angm};
    angn = side3_r.neg_ang ? -angx : angx;
    if (side3_r.zero) begin
      ang_nxt = '0;
    end else if (angn > SAT_HI) begin
      ang_nxt = OUT_W'(SAT_HI);
    end else if (angn < SAT_LO) begin
      ang_nxt = OUT_W'(SAT_LO);
    end else begin
      ang_nxt = angn[OUT_W-1:0];
    end
  end

  // Clear the valid flags under reset and advance them otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      v1_r       <= d_in.valid;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      out_strobe <= v3_r;
    end
  end

  // Advance the payload every cycle
  always_ff @(posedge clk) begin
    side1_r   <= d_in.side;
    r2_r      <= r2_full[R2_W-1:0];
    a_r       <= a_full[A_W-1:0];
    l1_r      <= l_full[L_W-1:0];
    side2_r   <= side1_r;
    c_r       <= c_full[C_W-1:0];
    l2_r      <= l1_r;
    side3_r   <= side2_r;
    sum_r     <= sum_nxt;
    out_angle <= ang_nxt;
  end

endmodule

`default_nettype wire

[rtl/atan2_cubic_approximation.sv]
`default_nettype none

// Vector angle by cubic fit. One request (in_y_value, in_x_value) may be
// issued every clock; busy is always low. The angle (Q2.13 radians) appears
// on out_angle with out_strobe high for one cycle, after the request has
// passed through the ratio divider, a row of 16 registered cells that each
// resolve one quotient bit per cycle, and then 4 polynomial stages (square,
// cube, sum, clamp); there is no way to stall it.
module atan2_cubic_approximation (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [atan2c_pkg::IN_W-1:0] in_y_value,
  input  wire logic signed [atan2c_pkg::IN_W-1:0] in_x_value,
  output logic                                    out_strobe,
  output logic signed [atan2c_pkg::OUT_W-1:0]     out_angle
);
  import atan2c_pkg::*;

  logic signed [IN_W:0]   y_s;
  logic signed [IN_W:0]   ay;
  logic signed [IN_W+1:0] x2;
  logic signed [IN_W+1:0] ay2;
  logic signed [IN_W+1:0] num;
  logic signed [IN_W+1:0] den;
  logic signed [IN_W+1:0] nmag;
  div_t                   chain [Q_W+1];

  assign busy = 1'b0;

  // Form ratio numerator and denominator for the quadrant
  always_comb begin
    y_s  = {in_y_value[IN_W-1], in_y_value};
    ay   = y_s[IN_W] ? -y_s : y_s;
    x2   = {{2{in_x_value[IN_W-1]}}, in_x_value};
    ay2  = {1'b0, ay};
    if (!in_x_value[IN_W-1]) begin
      num = x2 - ay2;
      den = x2 + ay2;
    end else begin
      num = x2 + ay2;
      den = ay2 - x2;
    end
    nmag = num[IN_W+1] ? -num : num;

    chain[0].valid        = start && !busy;
    chain[0].side.zero    = (in_y_value == '0) && (in_x_value == '0);
    chain[0].side.neg_ang = in_y_value[IN_W-1];
    chain[0].side.hi_off  = in_x_value[IN_W-1];
    chain[0].side.neg_q   = num[IN_W+1];
    chain[0].rem          = {1'b0, nmag[MAG_W-1:0]};
    chain[0].den          = den[MAG_W-1:0];
    chain[0].quo          = '0;
  end

  // Divider row: one cell per quotient bit
  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    atan2c_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  atan2c_poly u_poly (
    .clk        (clk),
    .rst_n      (rst_n),
    .d_in       (chain[Q_W]),
    .out_strobe (out_strobe),
    .out_angle  (out_angle)
  );

endmodule

`default_nettype wire

[rtl/atan2c_chk.sv]
`default_nettype none

`include "assert_macros.svh"

module atan2c_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic signed [atan2c_pkg::IN_W-1:0] in_y_value,
  input wire logic signed [atan2c_pkg::IN_W-1:0] in_x_value,
  input wire logic                               out_strobe,
  input wire logic signed [atan2c_pkg::OUT_W-1:0] out_angle
);
  import atan2c_pkg::*;

  // Every taken request comes back after the fixed latency
  `CHK_LATER(a_latency, clk, rst_n, start && !busy, LAT, out_strobe)

  // No result without a request the same latency earlier
  `CHK_IMPLY(a_source, clk, rst_n, out_strobe, $past(start && !busy, LAT))

  // Zero vector gives zero angle
  `CHK_IMPLY(a_zero, clk, rst_n, out_strobe && $past(in_y_value == '0 && in_x_value == '0, LAT), out_angle == '0)

  // Negative y never gives a positive angle
  `CHK_IMPLY(a_sign, clk, rst_n, out_strobe && $past(in_y_value[IN_W-1], LAT), out_angle[OUT_W-1] || out_angle == '0)

endmodule

bind atan2_cubic_approximation atan2c_chk u_chk (.*);

`default_nettype wire
